// ===== design/swm_pkg.sv =====
// Shared types and constants for the sliding window maximum block.
// No dependencies; imported by swm_cell and sliding_window_maximum_top.
package swm_pkg;

  localparam int DATA_W  = 32;
  localparam int WSIZE_W = 7;

  localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic signed [DATA_W-1:0] sample_t;

  typedef struct packed {
    logic load;       // a request is taken this cycle
    logic nbr_valid;  // neighbor cell covers samples of the current array
  } cell_ctl_t;

endpackage

// ===== design/swm_cell.sv =====
// One cell of the maximum chain: holds the maximum of the last (index + 1) samples.
// Depends on swm_pkg.
module swm_cell
  import swm_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  sample_t   sample,
  input  sample_t   nbr_max,
  output sample_t   cell_max
);

  sample_t cell_max_next;

  always_comb begin
    if (ctl.nbr_valid && (nbr_max > sample)) begin
      cell_max_next = nbr_max;
    end else begin
      cell_max_next = sample;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cell_max <= cell_max_next;
    end
  end

endmodule

// ===== design/sliding_window_maximum_top.sv =====
// Sliding window maximum: top level with the cell chain, fill count and output register.
// Depends on swm_pkg and swm_cell.
//
//   channel  signals                          direction
//   in       in_valid in_stall sample last_sample   request in
//   out      out_valid out_stall window_max       request out
//   cfg      cfg_we cfg_data                  register write
//
// One request per cycle unless stalled; results are registered once the window fills.
// Cell i of the chain holds the maximum of the last i+1 samples; all cells shift
// together on every taken request, and the result is read from cell window_size-2.
// rst clears the fill count, out_valid and window_size (to 1), but not window_max.
// in_stall follows out_stall while a result is held in the output register.
module sliding_window_maximum_top
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [DATA_W-1:0]  sample,
  input  logic                      last_sample,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [DATA_W-1:0]  window_max,
  input  logic                      cfg_we,
  input  logic [WSIZE_W-1:0]        cfg_data
);

  localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = $clog2(MAX_WINDOW + 1) + 1;

  logic [IW-1:0] tap;
  logic [IW-1:0] tap_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          in_acc;
  logic          emit;
  logic [IW-1:0] sel;
  sample_t       sel_max;
  sample_t       result;
  sample_t       cell_q [MAX_WINDOW];

  assign in_stall = out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign emit     = (count >= CW'(tap));
  assign sel      = tap - IW'(1);
  assign sel_max  = cell_q[sel];

  always_comb begin
    if (tap == '0) begin
      result = sample;
    end else if (sel_max > sample) begin
      result = sel_max;
    end else begin
      result = sample;
    end
  end

  always_comb begin
    if (cfg_data == '0) begin
      tap_next = '0;
    end else if (32'(cfg_data) > 32'(MAX_WINDOW)) begin
      tap_next = IW'(MAX_WINDOW - 1);
    end else begin
      tap_next = IW'(cfg_data - WSIZE_W'(1));
    end
  end

  always_comb begin
    count_next = count;
    if (cfg_we) begin
      count_next = '0;
    end else if (in_acc) begin
      if (last_sample) begin
        count_next = '0;
      end else if (count < CW'(MAX_WINDOW)) begin
        count_next = count + CW'(1);
      end
    end
  end

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    cell_ctl_t ctl;
    sample_t   nbr;
    assign ctl.load = in_acc;
    if (i == 0) begin : g_head
      assign ctl.nbr_valid = 1'b0;
      assign nbr           = INT_MIN;
    end else begin : g_body
      assign ctl.nbr_valid = (CW'(i - 1) < count);
      assign nbr           = cell_q[i-1];
    end
    swm_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .sample   (sample),
      .nbr_max  (nbr),
      .cell_max (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        tap <= tap_next;
      end
      count <= count_next;
      if (in_acc && emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      window_max <= result;
    end
  end

`ifndef ASSERT_OFF
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (count == '0))
    else $error("fill count not cleared by register write");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (in_acc && last_sample && !cfg_we) |=> (count == '0))
    else $error("fill count not cleared after last sample");

  a_max_ge_sample: assert property (@(posedge clk) disable iff (rst)
    (in_acc && emit) |=> (out_valid && (window_max >= $past(sample))))
    else $error("window maximum below newest sample");
`endif

endmodule
